>>> hw/rtl/ssuid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted set union/intersection/difference core.
// Used by ssuid_ctrl, ssuid_dp and sorted_set_union_intersect_diff_core; no dependencies.
package ssuid_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int MODE_W         = 2;
  localparam int VALUE_W        = 8;
  localparam int OP_W           = 2;

  // input item modes
  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

  // set_op register codes
  localparam logic [OP_W-1:0] OP_UNION = 2'd0;
  localparam logic [OP_W-1:0] OP_INTER = 2'd1;
  localparam logic [OP_W-1:0] OP_DIFF  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UNION,
    ST_FILTER,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_INIT,
    CMD_UNION,
    CMD_FILTER,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic            a_end;  // walk pointer reached count_a
    logic            b_end;  // walk pointer reached count_b
    logic [OP_W-1:0] op;     // current set_op register
  } status_t;

endpackage

>>> hw/rtl/ssuid_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the sorted set core.
// Depends on ssuid_pkg; drives ssuid_dp through cmd and reads its status.
module ssuid_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ssuid_pkg::MODE_W-1:0] mode,
  input  ssuid_pkg::status_t          status,
  output ssuid_pkg::cmd_t             cmd,
  output logic                        busy
);

  ssuid_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssuid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ssuid_pkg::ST_IDLE: begin
        if (start && mode == ssuid_pkg::MODE_RUN) begin
          case (status.op)
            ssuid_pkg::OP_UNION: state_next = ssuid_pkg::ST_UNION;
            ssuid_pkg::OP_INTER: state_next = ssuid_pkg::ST_FILTER;
            ssuid_pkg::OP_DIFF:  state_next = ssuid_pkg::ST_FILTER;
            default:             state_next = ssuid_pkg::ST_FINISH;
          endcase
        end
      end
      ssuid_pkg::ST_UNION: begin
        if (status.a_end && status.b_end) state_next = ssuid_pkg::ST_FINISH;
      end
      ssuid_pkg::ST_FILTER: begin
        if (status.a_end) state_next = ssuid_pkg::ST_FINISH;
      end
      ssuid_pkg::ST_FINISH: state_next = ssuid_pkg::ST_IDLE;
      default:              state_next = ssuid_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = ssuid_pkg::CMD_NONE;
    busy = 1'b1;
    case (state)
      ssuid_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (mode)
            ssuid_pkg::MODE_LOAD_A: cmd = ssuid_pkg::CMD_LOAD_A;
            ssuid_pkg::MODE_LOAD_B: cmd = ssuid_pkg::CMD_LOAD_B;
            ssuid_pkg::MODE_RUN:    cmd = ssuid_pkg::CMD_INIT;
            default:                cmd = ssuid_pkg::CMD_NONE;
          endcase
        end
      end
      ssuid_pkg::ST_UNION: begin
        if (!(status.a_end && status.b_end)) cmd = ssuid_pkg::CMD_UNION;
      end
      ssuid_pkg::ST_FILTER: begin
        if (!status.a_end) cmd = ssuid_pkg::CMD_FILTER;
      end
      ssuid_pkg::ST_FINISH: cmd = ssuid_pkg::CMD_FINISH;
      default:              cmd = ssuid_pkg::CMD_NONE;
    endcase
  end

endmodule

>>> hw/rtl/ssuid_dp.sv
`timescale 1ns / 1ps
// Datapath of the sorted set core: list stores, counts, walk pointers,
// pending item and output registers. Depends on ssuid_pkg.
module ssuid_dp #(
  parameter int LIST_DEPTH = ssuid_pkg::LIST_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ssuid_pkg::cmd_t              cmd,
  input  logic [ssuid_pkg::VALUE_W-1:0] value,
  input  logic                         cfg_we,
  input  logic [ssuid_pkg::OP_W-1:0]   cfg_data,
  output ssuid_pkg::status_t           status,
  output logic                         result_strobe,
  output logic [ssuid_pkg::VALUE_W-1:0] out_value,
  output logic                         is_last,
  output logic                         is_empty,
  output logic                         overflowed
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

  logic [ssuid_pkg::VALUE_W-1:0] store_a [LIST_DEPTH];
  logic [ssuid_pkg::VALUE_W-1:0] store_b [LIST_DEPTH];
  logic [CNT_W-1:0]              count_a, count_b;
  logic [CNT_W-1:0]              ptr_a, ptr_b;
  logic                          dropped;
  logic [ssuid_pkg::OP_W-1:0]    set_op;
  logic                          pend_valid;
  logic [ssuid_pkg::VALUE_W-1:0] pend_value;

  logic [ssuid_pkg::VALUE_W-1:0] elem_a, elem_b;
  logic                          a_end, b_end;
  logic                          new_item;
  logic [ssuid_pkg::VALUE_W-1:0] new_value;
  logic                          adv_a, adv_b, rewind_b;
  logic                          found;

  assign elem_a = store_a[ptr_a[IDX_W-1:0]];
  assign elem_b = store_b[ptr_b[IDX_W-1:0]];
  assign a_end  = (ptr_a == count_a);
  assign b_end  = (ptr_b == count_b);

  assign status.a_end = a_end;
  assign status.b_end = b_end;
  assign status.op    = set_op;

  assign found = !b_end && (elem_b == elem_a);

  // one walk step: which pointer moves and whether an element comes out
  always_comb begin
    new_item  = 1'b0;
    new_value = elem_a;
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    rewind_b  = 1'b0;
    case (cmd)
      ssuid_pkg::CMD_UNION: begin
        new_item = 1'b1;
        if (!a_end && !b_end) begin
          if (elem_a < elem_b) begin
            adv_a = 1'b1;
          end else if (elem_a > elem_b) begin
            new_value = elem_b;
            adv_b     = 1'b1;
          end else begin
            adv_a = 1'b1;
            adv_b = 1'b1;
          end
        end else if (!a_end) begin
          adv_a = 1'b1;
        end else begin
          new_value = elem_b;
          adv_b     = 1'b1;
        end
      end
      ssuid_pkg::CMD_FILTER: begin
        // scan B from its head for each A element
        if (!b_end && elem_b < elem_a) begin
          adv_b = 1'b1;
        end else begin
          adv_a    = 1'b1;
          rewind_b = 1'b1;
          new_item = (found == (set_op == ssuid_pkg::OP_INTER));
        end
      end
      default: ;
    endcase
  end

  // stores: no reset, only entries below the count are read
  always_ff @(posedge clk) begin
    if (cmd == ssuid_pkg::CMD_LOAD_A && count_a != FULL) begin
      store_a[count_a[IDX_W-1:0]] <= value;
    end
    if (cmd == ssuid_pkg::CMD_LOAD_B && count_b != FULL) begin
      store_b[count_b[IDX_W-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      ptr_a         <= '0;
      ptr_b         <= '0;
      dropped       <= 1'b0;
      set_op        <= ssuid_pkg::OP_UNION;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (new_item && pend_valid) || (cmd == ssuid_pkg::CMD_FINISH);
      if (cfg_we) set_op <= cfg_data;

      if (adv_a) ptr_a <= ptr_a + 1'b1;
      if (rewind_b) begin
        ptr_b <= '0;
      end else if (adv_b) begin
        ptr_b <= ptr_b + 1'b1;
      end

      // hold one item back so the last one can be marked
      if (new_item) begin
        pend_valid <= 1'b1;
        pend_value <= new_value;
        if (pend_valid) begin
          out_value     <= pend_value;
          is_last       <= 1'b0;
          is_empty      <= 1'b0;
          overflowed    <= dropped;
        end
      end

      case (cmd)
        ssuid_pkg::CMD_LOAD_A: begin
          if (count_a != FULL) count_a <= count_a + 1'b1;
          else dropped <= 1'b1;
        end
        ssuid_pkg::CMD_LOAD_B: begin
          if (count_b != FULL) count_b <= count_b + 1'b1;
          else dropped <= 1'b1;
        end
        ssuid_pkg::CMD_INIT: begin
          ptr_a      <= '0;
          ptr_b      <= '0;
          pend_valid <= 1'b0;
        end
        ssuid_pkg::CMD_FINISH: begin
          out_value     <= pend_valid ? pend_value : '0;
          is_last       <= 1'b1;
          is_empty      <= !pend_valid;
          overflowed    <= dropped;
          pend_valid    <= 1'b0;
          count_a       <= '0;
          count_b       <= '0;
          dropped       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/sorted_set_union_intersect_diff_core.sv
`timescale 1ns / 1ps
// Top level of the sorted set union/intersection/difference core.
// Depends on ssuid_pkg, ssuid_ctrl and ssuid_dp.
//
// Load list A (mode 0) and list B (mode 1) one byte per item, each in
// ascending order; loads leave busy low, so loads may be issued on every
// cycle. A run item (mode 2) walks the lists with the operation held in
// set_op and emits its results on result_strobe, one cycle each, with no way
// to stall them: the receiver must take every strobed cycle. The final item
// of a run carries is_last; an empty answer is a single item with is_empty
// set and out_value zero. busy stays high from the accepted run item until
// the final result is on the ports. Run length is set by the controller's
// walk loop, which does one compare per cycle: union merges the two lists,
// intersection and difference scan B from its head for each A element, and
// an unused set_op code goes straight to an empty final item. Results come
// out one per cycle in union, spaced by the B scan otherwise. A run clears
// both counts and the overflow flag; a load into a full list is dropped and
// flagged on the next run's items. Write set_op only while busy is low.
module sorted_set_union_intersect_diff_core #(
  parameter int LIST_DEPTH = ssuid_pkg::LIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item input
  input  logic                          start,
  output logic                          busy,
  input  logic [ssuid_pkg::MODE_W-1:0]  mode,
  input  logic [ssuid_pkg::VALUE_W-1:0] value,
  // configuration
  input  logic                          cfg_we,
  input  logic [ssuid_pkg::OP_W-1:0]    cfg_data,
  // results
  output logic                          result_strobe,
  output logic [ssuid_pkg::VALUE_W-1:0] out_value,
  output logic                          is_last,
  output logic                          is_empty,
  output logic                          overflowed
);

  ssuid_pkg::cmd_t    cmd;
  ssuid_pkg::status_t status;

  // sequence loads and the walk
  ssuid_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // hold the lists and advance the walk
  ssuid_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .value         (value),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .status        (status),
    .result_strobe (result_strobe),
    .out_value     (out_value),
    .is_last       (is_last),
    .is_empty      (is_empty),
    .overflowed    (overflowed)
  );

  // an empty answer is always the only, and so the final, item
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && is_empty |-> is_last && out_value == '0)
    else $error("empty result item not final or value nonzero");

  // the final item appears once the controller is back to idle
  a_last_not_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && is_last |-> !busy)
    else $error("final result item while still busy");

  // an accepted run item makes the block busy in the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == ssuid_pkg::MODE_RUN |=> busy)
    else $error("run item accepted but block not busy");

  // loads never produce results
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode != ssuid_pkg::MODE_RUN |=> !result_strobe)
    else $error("result item after a load");

endmodule
